>>> hw/rtl/uv_sphere_vertex_generator_macros.svh
// Assertion macros used by the checker module of the vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication does not hold");

// Next-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication does not hold");

`endif

>>> hw/rtl/uvs_pkg.sv
// Package with the constants, tables and types of the UV sphere vertex generator.
package uvs_pkg;

	localparam int DEF_MAX_SECTORS  = 1024;
	localparam int DEF_MAX_STACKS   = 1024;
	localparam int DEF_CORDIC_STEPS = 16;

	localparam int IDX_W      = 11;
	localparam int RADIUS_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int POS_W      = 17;
	localparam int NRM_W      = 16;
	localparam int TEX_W      = 17;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 136;
	localparam int DIV_STEPS  = 33;
	localparam int QUO_W      = 34;
	localparam int ATAN_LEN   = 24;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPHERE_RADIUS = 2'd0,
		REG_SECTOR_TOTAL  = 2'd1,
		REG_STACK_TOTAL   = 2'd2
	} reg_idx_t;

endpackage

>>> hw/rtl/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator: dividers, CORDIC and scaling pipeline.
//
// Usage. Grid points arrive on the slave stream (s_tvalid, s_tready, s_tdata) as a
// stack index and a sector index; each transfer gives exactly one vertex on the master
// stream (m_tvalid, m_tready, m_tdata, m_tuser) carrying position, normal and texture
// coordinates, with m_tuser flagging an index beyond its configured count (all other
// fields are then zero). Radius and grid counts are written over the cfg channel, which
// is always ready and must only be used while no transfer is in flight.
// One vertex enters per cycle while s_tready is high; the two 33-stage restoring
// dividers yield one quotient bit per stage, the CORDIC units one rotation per stage.
// Reset clears the stage valid bits and loads radius 1.0, 36 sectors and 18 stacks.
// When the receiver stalls, the output register holds its transfer; the pipeline keeps
// moving while its last stage is empty, so bubbles close up, and s_tready falls only
// once a finished vertex waits behind the held one.
module uv_sphere_vertex_generator
	import uvs_pkg::*;
#(
	parameter int MAX_SECTORS  = DEF_MAX_SECTORS,
	parameter int MAX_STACKS   = DEF_MAX_STACKS,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RADIUS_W-1:0]  cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// stack_index [10:0], sector_index [21:11], zero pad [23:22]
	input  logic [S_DATA_W-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, zero pad
	output logic [M_DATA_W-1:0]  m_tdata,
	// index_error
	output logic                 m_tuser
);

	localparam logic [12:0] MAX_S = 13'(MAX_SECTORS);
	localparam logic [12:0] MAX_T = 13'(MAX_STACKS);

	logic [RADIUS_W-1:0] radius_q;
	logic [IDX_W-1:0]    sector_total_q;
	logic [IDX_W-1:0]    stack_total_q;
	logic [IDX_W-1:0]    sectors;
	logic [IDX_W-1:0]    stacks;
	logic                en;
	logic                out_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= 16'd256;
			sector_total_q <= 11'd36;
			stack_total_q  <= 11'd18;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SPHERE_RADIUS: radius_q       <= cfg_data;
				REG_SECTOR_TOTAL:  sector_total_q <= cfg_data[IDX_W-1:0];
				REG_STACK_TOTAL:   stack_total_q  <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sector_total_q < 11'd3) begin
			sectors = 11'd3;
		end else if ({2'b00, sector_total_q} > MAX_S) begin
			sectors = MAX_S[IDX_W-1:0];
		end else begin
			sectors = sector_total_q;
		end
		if (stack_total_q < 11'd2) begin
			stacks = 11'd2;
		end else if ({2'b00, stack_total_q} > MAX_T) begin
			stacks = MAX_T[IDX_W-1:0];
		end else begin
			stacks = stack_total_q;
		end
	end

	// Divider pipelines; index 0 is the input stage.
	logic [11:0]      ra_d [0:DIV_STEPS];
	logic [11:0]      rb_d [0:DIV_STEPS];
	logic [QUO_W-1:0] qa_d [0:DIV_STEPS];
	logic [QUO_W-1:0] qb_d [0:DIV_STEPS];
	logic             err_d [0:DIV_STEPS];
	logic             v_d [0:DIV_STEPS];

	logic [IDX_W-1:0] in_i;
	logic [IDX_W-1:0] in_j;
	assign in_i = s_tdata[10:0];
	assign in_j = s_tdata[21:11];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (en) begin
			v_d[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_d[0] <= (in_i > stacks) || (in_j > sectors);
			ra_d[0]  <= (in_j == sectors) ? 12'd0 : {1'b0, in_j};
			rb_d[0]  <= (in_i == stacks) ? 12'd0 : {1'b0, in_i};
			qa_d[0]  <= {{(QUO_W-1){1'b0}}, in_j == sectors};
			qb_d[0]  <= {{(QUO_W-1){1'b0}}, in_i == stacks};
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [11:0] ta;
		logic [11:0] tb;
		logic        ga;
		logic        gb;
		assign ta = {ra_d[k][10:0], 1'b0};
		assign tb = {rb_d[k][10:0], 1'b0};
		assign ga = ta >= {1'b0, sectors};
		assign gb = tb >= {1'b0, stacks};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (en) begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_d[k+1]  <= ga ? ta - {1'b0, sectors} : ta;
				rb_d[k+1]  <= gb ? tb - {1'b0, stacks} : tb;
				qa_d[k+1]  <= {qa_d[k][QUO_W-2:0], ga};
				qb_d[k+1]  <= {qb_d[k][QUO_W-2:0], gb};
				err_d[k+1] <= err_d[k];
			end
		end
	end

	// Phase, texture and quadrant stage.
	logic [31:0] pt;
	logic [31:0] ps;
	logic [31:0] pt_off;
	logic [31:0] ps_off;
	logic [17:0] tu_sum;
	logic [17:0] tv_sum;

	assign pt     = qa_d[DIV_STEPS][32:1];
	assign ps     = 32'h4000_0000 - qb_d[DIV_STEPS][33:2];
	assign pt_off = pt + 32'h2000_0000;
	assign ps_off = ps + 32'h2000_0000;
	assign tu_sum = qa_d[DIV_STEPS][33:16] + 18'd1;
	assign tv_sum = qb_d[DIV_STEPS][33:16] + 18'd1;

	logic signed [32:0] zs_p;
	logic signed [32:0] zt_p;
	logic [1:0]         qs_p;
	logic [1:0]         qt_p;
	logic [TEX_W-1:0]   tu_p;
	logic [TEX_W-1:0]   tv_p;
	logic               err_p;
	logic               v_p;
	logic [31:0]        rs;
	logic [31:0]        rt;

	assign rs = ps - {ps_off[31:30], 30'd0};
	assign rt = pt - {pt_off[31:30], 30'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= v_d[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qs_p  <= ps_off[31:30];
			qt_p  <= pt_off[31:30];
			zs_p  <= {rs[31], rs};
			zt_p  <= {rt[31], rt};
			tu_p  <= tu_sum[17:1];
			tv_p  <= tv_sum[17:1];
			err_p <= err_d[DIV_STEPS];
		end
	end

	// CORDIC pipelines, one rotation per stage.
	logic signed [33:0] xs_c [0:CORDIC_STEPS];
	logic signed [33:0] ys_c [0:CORDIC_STEPS];
	logic signed [32:0] zs_c [0:CORDIC_STEPS];
	logic signed [33:0] xt_c [0:CORDIC_STEPS];
	logic signed [33:0] yt_c [0:CORDIC_STEPS];
	logic signed [32:0] zt_c [0:CORDIC_STEPS];
	logic [1:0]         qs_c [0:CORDIC_STEPS];
	logic [1:0]         qt_c [0:CORDIC_STEPS];
	logic [TEX_W-1:0]   tu_c [0:CORDIC_STEPS];
	logic [TEX_W-1:0]   tv_c [0:CORDIC_STEPS];
	logic               err_c [0:CORDIC_STEPS];
	logic               v_c [0:CORDIC_STEPS];

	assign xs_c[0]  = CORDIC_GAIN;
	assign ys_c[0]  = '0;
	assign zs_c[0]  = zs_p;
	assign xt_c[0]  = CORDIC_GAIN;
	assign yt_c[0]  = '0;
	assign zt_c[0]  = zt_p;
	assign qs_c[0]  = qs_p;
	assign qt_c[0]  = qt_p;
	assign tu_c[0]  = tu_p;
	assign tv_c[0]  = tv_p;
	assign err_c[0] = err_p;
	assign v_c[0]   = v_p;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		logic signed [32:0] ang;
		logic signed [33:0] dxs;
		logic signed [33:0] dys;
		logic signed [33:0] dxt;
		logic signed [33:0] dyt;
		assign ang = $signed({1'b0, ATAN_TURNS[k]});
		assign dxs = ys_c[k] >>> k;
		assign dys = xs_c[k] >>> k;
		assign dxt = yt_c[k] >>> k;
		assign dyt = xt_c[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[k+1] <= 1'b0;
			end else if (en) begin
				v_c[k+1] <= v_c[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zs_c[k][32]) begin
					xs_c[k+1] <= xs_c[k] - dxs;
					ys_c[k+1] <= ys_c[k] + dys;
					zs_c[k+1] <= zs_c[k] - ang;
				end else begin
					xs_c[k+1] <= xs_c[k] + dxs;
					ys_c[k+1] <= ys_c[k] - dys;
					zs_c[k+1] <= zs_c[k] + ang;
				end
				if (!zt_c[k][32]) begin
					xt_c[k+1] <= xt_c[k] - dxt;
					yt_c[k+1] <= yt_c[k] + dyt;
					zt_c[k+1] <= zt_c[k] - ang;
				end else begin
					xt_c[k+1] <= xt_c[k] + dxt;
					yt_c[k+1] <= yt_c[k] - dyt;
					zt_c[k+1] <= zt_c[k] + ang;
				end
				qs_c[k+1]  <= qs_c[k];
				qt_c[k+1]  <= qt_c[k];
				tu_c[k+1]  <= tu_c[k];
				tv_c[k+1]  <= tv_c[k];
				err_c[k+1] <= err_c[k];
			end
		end
	end

	// Quadrant mapping stage.
	function automatic logic signed [63:0] quad_map(
		input logic [1:0]         q,
		input logic signed [33:0] x,
		input logic signed [33:0] y
	);
		logic signed [31:0] c;
		logic signed [31:0] s;
		case (q)
			2'd0: begin
				c = 32'(x);
				s = 32'(y);
			end
			2'd1: begin
				c = 32'(-y);
				s = 32'(x);
			end
			2'd2: begin
				c = 32'(-x);
				s = 32'(-y);
			end
			default: begin
				c = 32'(y);
				s = 32'(-x);
			end
		endcase
		return {c, s};
	endfunction

	logic signed [63:0] ms;
	logic signed [63:0] mt;
	assign ms = quad_map(qs_c[CORDIC_STEPS], xs_c[CORDIC_STEPS], ys_c[CORDIC_STEPS]);
	assign mt = quad_map(qt_c[CORDIC_STEPS], xt_c[CORDIC_STEPS], yt_c[CORDIC_STEPS]);

	logic signed [31:0] cs_m;
	logic signed [31:0] ss_m;
	logic signed [31:0] ct_m;
	logic signed [31:0] st_m;
	logic [TEX_W-1:0]   tu_m;
	logic [TEX_W-1:0]   tv_m;
	logic               err_m;
	logic               v_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else if (en) begin
			v_m <= v_c[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_m  <= ms[63:32];
			ss_m  <= ms[31:0];
			ct_m  <= mt[63:32];
			st_m  <= mt[31:0];
			tu_m  <= tu_c[CORDIC_STEPS];
			tv_m  <= tv_c[CORDIC_STEPS];
			err_m <= err_c[CORDIC_STEPS];
		end
	end

	// Direction products.
	logic signed [63:0] px_u;
	logic signed [63:0] py_u;
	logic signed [31:0] nz_u;
	logic [TEX_W-1:0]   tu_u;
	logic [TEX_W-1:0]   tv_u;
	logic               err_u;
	logic               v_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_u <= 1'b0;
		end else if (en) begin
			v_u <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_u  <= cs_m * ct_m;
			py_u  <= cs_m * st_m;
			nz_u  <= ss_m;
			tu_u  <= tu_m;
			tv_u  <= tv_m;
			err_u <= err_m;
		end
	end

	// Rounding back to Q1.30 and conversion of the normals to Q1.15.
	function automatic logic signed [NRM_W-1:0] to_q15(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] r;
		t = {v[32], v} + 34'sd16384;
		r = t[33:15];
		if (r > 19'sd32767) begin
			return 16'sh7FFF;
		end else if (r < -19'sd32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	logic signed [63:0] rx_sum;
	logic signed [63:0] ry_sum;
	logic signed [32:0] nx_v;
	logic signed [32:0] ny_v;
	logic signed [32:0] nz_v;

	assign rx_sum = px_u + 64'sd536870912;
	assign ry_sum = py_u + 64'sd536870912;
	assign nx_v   = rx_sum[62:30];
	assign ny_v   = ry_sum[62:30];
	assign nz_v   = {nz_u[31], nz_u};

	logic signed [32:0]      nx_n;
	logic signed [32:0]      ny_n;
	logic signed [32:0]      nz_n;
	logic signed [NRM_W-1:0] qx_n;
	logic signed [NRM_W-1:0] qy_n;
	logic signed [NRM_W-1:0] qz_n;
	logic [TEX_W-1:0]        tu_n;
	logic [TEX_W-1:0]        tv_n;
	logic                    err_n;
	logic                    v_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n <= 1'b0;
		end else if (en) begin
			v_n <= v_u;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_n  <= nx_v;
			ny_n  <= ny_v;
			nz_n  <= nz_v;
			qx_n  <= to_q15(nx_v);
			qy_n  <= to_q15(ny_v);
			qz_n  <= to_q15(nz_v);
			tu_n  <= tu_u;
			tv_n  <= tv_u;
			err_n <= err_u;
		end
	end

	// Radius products.
	logic signed [16:0] radius_s;
	assign radius_s = $signed({1'b0, radius_q});

	logic signed [49:0]      px_w;
	logic signed [49:0]      py_w;
	logic signed [49:0]      pz_w;
	logic signed [NRM_W-1:0] qx_w;
	logic signed [NRM_W-1:0] qy_w;
	logic signed [NRM_W-1:0] qz_w;
	logic [TEX_W-1:0]        tu_w;
	logic [TEX_W-1:0]        tv_w;
	logic                    err_w;
	logic                    v_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_w <= 1'b0;
		end else if (en) begin
			v_w <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_w  <= radius_s * nx_n;
			py_w  <= radius_s * ny_n;
			pz_w  <= radius_s * nz_n;
			qx_w  <= qx_n;
			qy_w  <= qy_n;
			qz_w  <= qz_n;
			tu_w  <= tu_n;
			tv_w  <= tv_n;
			err_w <= err_n;
		end
	end

	// Position rounding, saturation and packing.
	function automatic logic signed [POS_W-1:0] to_pos(input logic signed [49:0] p);
		logic signed [50:0] t;
		logic signed [20:0] r;
		t = {p[49], p} + 51'sd536870912;
		r = t[50:30];
		if (r > 21'sd65535) begin
			return 17'sh0FFFF;
		end else if (r < -21'sd65536) begin
			return 17'sh10000;
		end
		return r[16:0];
	endfunction

	logic [M_DATA_W-1:0] data_f;
	logic                err_f;
	logic                v_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f <= 1'b0;
		end else if (en) begin
			v_f <= v_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_f <= err_w;
			if (err_w) begin
				data_f <= '0;
			end else begin
				data_f <= {3'b000, tv_w, tu_w, qz_w, qy_w, qx_w,
					to_pos(pz_w), to_pos(py_w), to_pos(px_w)};
			end
		end
	end

	// Output register.
	assign out_load = !m_tvalid || m_tready;
	assign en       = out_load || !v_f;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= v_f;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= data_f;
			m_tuser <= err_f;
		end
	end

endmodule

>>> hw/rtl/uvs_checker.sv
// Port-level checker of the UV sphere vertex generator and its bind statement.
`include "uv_sphere_vertex_generator_macros.svh"

module uvs_checker
	import uvs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser
);

	// A held transfer keeps its payload.
	`UVS_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A flagged vertex carries only zeros.
	`UVS_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)

	// Texture u never exceeds one.
	`UVS_ASSERT_IMP(a_tex_u, clk, arst_n, m_tvalid, m_tdata[115:99] <= 17'd65536)

	// The input side stalls only behind a held output transfer.
	`UVS_ASSERT_IMP(a_stall, clk, arst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

>>> bench/tb_top.sv
// Self-checking testbench of the UV sphere vertex generator with its own vertex predictor.
module tb_top;
	import uvs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int CHOKE_CYCLES = 400;

	typedef struct {
		logic [IDX_W-1:0] stack;
		logic [IDX_W-1:0] sector;
	} grid_point_t;

	typedef struct {
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [NRM_W-1:0] nx, ny, nz;
		logic [TEX_W-1:0] tu, tv;
		logic err;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RADIUS_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic m_tuser;

	grid_point_t point_q[$];
	vertex_t vertex_q[$];
	logic [15:0] radius_cfg = 16'd256;
	logic [10:0] sectors_cfg = 11'd36;
	logic [10:0] stacks_cfg = 11'd18;
	int fail_count = 0;
	int vertex_count = 0;
	int point_count = 0;
	int cycle_count = 0;
	bit steady = 1'b0;
	bit choke_req = 1'b0;
	bit choke_done = 1'b0;
	int choke_left = 0;

	uv_sphere_vertex_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_shift(input longint v, input int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void rotate_angle(input logic [31:0] ph, output longint c,
			output longint s);
		logic [31:0] sum;
		logic [1:0] quad;
		logic [31:0] rest;
		longint x, y, z, dx, dy;
		sum = ph + 32'h2000_0000;
		quad = sum[31:30];
		rest = ph - {quad, 30'b0};
		z = longint'($signed(rest));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int k = 0; k < DEF_CORDIC_STEPS && k < ATAN_LEN; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
			end
		end
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic vertex_t grid_vertex(input grid_point_t p);
		vertex_t v;
		longint sectors, stacks, cs, ss, ct, st, nx, ny, r;
		logic [63:0] wide;
		logic [31:0] pt, ps;
		v = '{default: '0};
		sectors = clip(longint'(sectors_cfg), 3, DEF_MAX_SECTORS);
		stacks = clip(longint'(stacks_cfg), 2, DEF_MAX_STACKS);
		if (longint'(p.stack) > stacks || longint'(p.sector) > sectors) begin
			v.err = 1'b1;
			return v;
		end
		wide = (longint'(p.sector) <<< 32) / sectors;
		pt = wide[31:0];
		wide = (longint'(p.stack) <<< 31) / stacks;
		ps = 32'h4000_0000 - wide[31:0];
		rotate_angle(ps, cs, ss);
		rotate_angle(pt, ct, st);
		nx = round_shift(cs * ct, 30);
		ny = round_shift(cs * st, 30);
		r = longint'(radius_cfg);
		v.px = POS_W'(clip(round_shift(r * nx, 30), -65536, 65535));
		v.py = POS_W'(clip(round_shift(r * ny, 30), -65536, 65535));
		v.pz = POS_W'(clip(round_shift(r * ss, 30), -65536, 65535));
		v.nx = NRM_W'(clip(round_shift(nx, 15), -32768, 32767));
		v.ny = NRM_W'(clip(round_shift(ny, 15), -32768, 32767));
		v.nz = NRM_W'(clip(round_shift(ss, 15), -32768, 32767));
		v.tu = TEX_W'((longint'(p.sector) * 131072 + sectors) / (2 * sectors));
		v.tv = TEX_W'((longint'(p.stack) * 131072 + stacks) / (2 * stacks));
		return v;
	endfunction

	function automatic int draw_wait();
		if (steady || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Driver: one transfer per grid point, with a random gap after each.
	int send_gap = 0;
	always @(posedge clk) begin
		grid_point_t p;
		logic nv;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			nv = 1'b0;
			if (s_tvalid && s_tready) begin
				p.stack = s_tdata[10:0];
				p.sector = s_tdata[21:11];
				vertex_q = {vertex_q, grid_vertex(p)};
				point_count++;
			end
			if (s_tvalid && !s_tready)
				nv = 1'b1;
			else if (send_gap > 0)
				send_gap--;
			else if (point_q.size() > 0) begin
				p = point_q.pop_front();
				s_tdata <= {2'b00, p.sector, p.stack};
				nv = 1'b1;
				send_gap = draw_wait();
			end
			s_tvalid <= nv;
		end
	end

	// A single long hold-off of the receiver, counted down in cycles.
	always @(posedge clk) begin
		if (choke_req && !choke_done) begin
			choke_done <= 1'b1;
			choke_left <= CHOKE_CYCLES;
		end else if (choke_left > 0)
			choke_left <= choke_left - 1;
	end

	// Monitor: compares each vertex transfer with the oldest prediction.
	int hold = 0;
	always @(posedge clk) begin
		vertex_t e, a;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				a.px = m_tdata[16:0];
				a.py = m_tdata[33:17];
				a.pz = m_tdata[50:34];
				a.nx = m_tdata[66:51];
				a.ny = m_tdata[82:67];
				a.nz = m_tdata[98:83];
				a.tu = m_tdata[115:99];
				a.tv = m_tdata[132:116];
				a.err = m_tuser;
				vertex_count++;
				if (vertex_q.size() == 0) begin
					$error("vertex transfer with no prediction waiting");
					fail_count++;
				end else begin
					e = vertex_q.pop_front();
					if (a.px !== e.px) begin
						$error("pos_x expected %0d got %0d", e.px, a.px); fail_count++;
					end
					if (a.py !== e.py) begin
						$error("pos_y expected %0d got %0d", e.py, a.py); fail_count++;
					end
					if (a.pz !== e.pz) begin
						$error("pos_z expected %0d got %0d", e.pz, a.pz); fail_count++;
					end
					if (a.nx !== e.nx) begin
						$error("normal_x expected %0d got %0d", e.nx, a.nx); fail_count++;
					end
					if (a.ny !== e.ny) begin
						$error("normal_y expected %0d got %0d", e.ny, a.ny); fail_count++;
					end
					if (a.nz !== e.nz) begin
						$error("normal_z expected %0d got %0d", e.nz, a.nz); fail_count++;
					end
					if (a.tu !== e.tu) begin
						$error("tex_u expected %0d got %0d", e.tu, a.tu); fail_count++;
					end
					if (a.tv !== e.tv) begin
						$error("tex_v expected %0d got %0d", e.tv, a.tv); fail_count++;
					end
					if (a.err !== e.err) begin
						$error("index_error expected %0d got %0d", e.err, a.err);
						fail_count++;
					end
				end
				hold = draw_wait();
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else
				m_tready <= (choke_left == 0);
		end
	end

	always @(posedge clk)
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SPHERE_RADIUS: radius_cfg = val;
			REG_SECTOR_TOTAL: sectors_cfg = val[10:0];
			REG_STACK_TOTAL: stacks_cfg = val[10:0];
			default: ;
		endcase
	endtask

	task automatic add_point(input int i, input int j);
		grid_point_t p;
		p.stack = i[10:0];
		p.sector = j[10:0];
		point_q = {point_q, p};
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (point_q.size() > 0 || s_tvalid || vertex_q.size() > 0);
	endtask

	task automatic add_random(input int n);
		int sectors, stacks;
		sectors = sectors_cfg < 3 ? 3 : (sectors_cfg > 1024 ? 1024 : sectors_cfg);
		stacks = stacks_cfg < 2 ? 2 : (stacks_cfg > 1024 ? 1024 : stacks_cfg);
		for (int k = 0; k < n; k++)
			if ($urandom_range(0, 9) == 0)
				add_point($urandom_range(0, 2047), $urandom_range(0, 2047));
			else
				add_point($urandom_range(0, stacks), $urandom_range(0, sectors));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration first, then the largest radius and grid counts written explicitly.
		add_point(0, 0); add_point(18, 36); add_point(9, 0); add_point(9, 9);
		add_point(9, 18); add_point(9, 27); add_point(3, 7); add_point(19, 0);
		add_point(0, 37); add_point(2047, 2047); add_point(1024, 1024);
		add_point(1365, 682); add_point(682, 1365);
		wait_idle();
		write_reg(REG_SPHERE_RADIUS, 16'hFFFF);
		write_reg(REG_SECTOR_TOTAL, 16'd1024);
		write_reg(REG_STACK_TOTAL, 16'd1024);
		add_point(0, 0); add_point(1024, 1024); add_point(512, 256); add_point(512, 512);
		add_point(1, 1023); add_point(1023, 1); add_point(511, 768); add_point(1025, 5);
		steady = 1'b1;
		add_random(200);
		wait_idle();

		steady = 1'b0;
		write_reg(REG_SPHERE_RADIUS, 16'd0);
		write_reg(REG_SECTOR_TOTAL, 16'd3);
		write_reg(REG_STACK_TOTAL, 16'd2);
		add_random(150);
		choke_req = 1'b1;
		add_random(150);
		wait_idle();

		write_reg(REG_SPHERE_RADIUS, 16'd1);
		write_reg(REG_SECTOR_TOTAL, 16'hFFFF);
		write_reg(REG_STACK_TOTAL, 16'd1);
		write_reg(REG_UNUSED, 16'h1234);
		add_random(250);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_SPHERE_RADIUS, 16'($urandom_range(1, 65535)));
			write_reg(REG_SECTOR_TOTAL, 16'($urandom_range(0, 2047)));
			write_reg(REG_STACK_TOTAL, 16'($urandom_range(0, 2047)));
			if (ph == 2)
				write_reg(REG_UNUSED, 16'($urandom));
			steady = (ph == 1);
			add_random(250);
			wait_idle();
		end

		repeat (100) @(posedge clk);
		$display("Checked %0d vertices from %0d grid points over eight configurations,",
			vertex_count, point_count);
		$display("including count clamping, zero radius and out-of-range indices.");
		if (fail_count == 0 && vertex_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
